// ===== rtl/core/mdds_pkg.sv =====
// Package for the morphing digit draw sequencer.
// Holds types, codes, constants and the per-slot command table function.
// Used by all modules in rtl/core.
`timescale 1ns / 1ps

package mdds_pkg;

   localparam int SEG_LEN       = 6;
   localparam int PANEL_TOP_ROW = 31;
   localparam int MAX_RESULTS   = 64;

   localparam logic [3:0] SHOW_SLOT   = 4'd8;
   localparam logic [3:0] PROG_DIRECT = 4'd10;
   localparam logic [3:0] PROG_COLON  = 4'd11;

   localparam logic [1:0] OP_MORPH  = 2'd0;
   localparam logic [1:0] OP_DRAW   = 2'd1;
   localparam logic [1:0] OP_COLON  = 2'd2;
   localparam logic [1:0] OP_UNUSED = 2'd3;

   localparam logic [1:0] KIND_PIXEL = 2'd0;
   localparam logic [1:0] KIND_LINE  = 2'd1;
   localparam logic [1:0] KIND_RECT  = 2'd2;
   localparam logic [1:0] KIND_SHOW  = 2'd3;

   localparam logic [1:0] CSEL_BLACK = 2'd0;
   localparam logic [1:0] CSEL_LIT   = 2'd1;
   localparam logic [1:0] CSEL_COLON = 2'd2;

   localparam logic [1:0] CSR_X_ORIGIN  = 2'd0;
   localparam logic [1:0] CSR_Y_ORIGIN  = 2'd1;
   localparam logic [1:0] CSR_LIT_COLOR = 2'd2;

   localparam logic [7:0] SEG_MASKS [10] = '{
      8'hFC, 8'h60, 8'hDA, 8'hF2, 8'h66, 8'hB6, 8'hBE, 8'hE0, 8'hFE, 8'hF6
   };

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_SEND
   } state_type;

   // one draw slot in digit-local coordinates
   typedef struct packed {
      logic              en;
      logic [1:0]        kind;
      logic [1:0]        csel;
      logic signed [7:0] x1;
      logic signed [7:0] y1;
      logic signed [7:0] x2;
      logic signed [7:0] y2;
      logic signed [7:0] w;
      logic signed [7:0] h;
   } slot_type;

   typedef struct packed {
      logic load_req;
      logic load_out;
      logic last;
   } ctrl_cmd_type;

   typedef struct packed {
      logic       op_none;
      logic       slot_en;
      logic [3:0] nframes;
   } dp_stat_type;

   function automatic slot_type mk(logic en, logic [1:0] kind, int x1, int y1,
                                   int x2, int y2, int w, int h, logic [1:0] csel);
      slot_type r;
      r.en   = en;
      r.kind = kind;
      r.csel = csel;
      r.x1   = 8'(x1);
      r.y1   = 8'(y1);
      r.x2   = 8'(x2);
      r.y2   = 8'(y2);
      r.w    = 8'(w);
      r.h    = 8'(h);
      return r;
   endfunction

   function automatic slot_type pix(logic en, int x, int y, logic [1:0] c);
      return mk(en, KIND_PIXEL, x, y, x, y, 0, 0, c);
   endfunction

   function automatic slot_type ln(logic en, int x, int y, int x2, int y2, logic [1:0] c);
      return mk(en, KIND_LINE, x, y, x2, y2, 0, 0, c);
   endfunction

   function automatic slot_type bar(logic en, int x, int a, int b, logic [1:0] c);
      return mk(en, KIND_LINE, x, a, x, b, 0, 0, c);
   endfunction

   function automatic slot_type rct(int x, int y, int w, int h, logic [1:0] c);
      return mk(1'b1, KIND_RECT, x, y, 0, 0, w, h, c);
   endfunction

   function automatic logic [3:0] frame_count(logic [3:0] prog);
      logic [3:0] n;
      case (prog)
         4'd4, 4'd5:        n = 4'(SEG_LEN);
         4'd1, 4'd7, 4'd9:  n = 4'(SEG_LEN + 2);
         PROG_DIRECT, PROG_COLON: n = 4'd1;
         default:           n = 4'(SEG_LEN + 1);
      endcase
      return n;
   endfunction

   // command for slot j of frame i; slot SHOW_SLOT is always the show
   function automatic slot_type cmd_slot(logic [3:0] prog, logic [3:0] from, logic [3:0] fi,
                                         logic [3:0] j, logic [7:0] mask);
      int s;
      int i;
      logic f123;
      logic f59;
      slot_type r;
      s = SEG_LEN;
      i = int'(fi);
      f123 = (from == 4'd1) || (from == 4'd2) || (from == 4'd3);
      f59  = (from == 4'd5) || (from == 4'd9);
      r = mk(1'b0, KIND_PIXEL, 0, 0, 0, 0, 0, 0, CSEL_BLACK);
      if (j == SHOW_SLOT) begin
         r = mk(1'b1, KIND_SHOW, 0, 0, 0, 0, 0, 0, CSEL_BLACK);
      end else begin
         case (prog)
            PROG_DIRECT: begin
               case (j)
                  4'd0: r = rct(0, 0, s + 2, 2 * s + 3, CSEL_BLACK);
                  4'd1: r = ln(mask[7], 1, 2 * s + 2, s, 2 * s + 2, CSEL_LIT);
                  4'd2: r = ln(mask[6], s + 1, 2 * s + 1, s + 1, s + 2, CSEL_LIT);
                  4'd3: r = ln(mask[5], s + 1, 1, s + 1, s, CSEL_LIT);
                  4'd4: r = ln(mask[4], 1, 0, s, 0, CSEL_LIT);
                  4'd5: r = ln(mask[3], 0, 1, 0, s, CSEL_LIT);
                  4'd6: r = ln(mask[2], 0, 2 * s + 1, 0, s + 2, CSEL_LIT);
                  4'd7: r = ln(mask[1], 1, s + 1, s, s + 1, CSEL_LIT);
                  default: ;
               endcase
            end
            PROG_COLON: begin
               case (j)
                  4'd0: r = rct(-3, s - 2, 2, 2, CSEL_COLON);
                  4'd1: r = rct(-3, s + 3, 2, 2, CSEL_COLON);
                  default: ;
               endcase
            end
            4'd2: begin
               case (j)
                  4'd0: r = pix(i < s, s - i, 2 * s + 2, CSEL_LIT);
                  4'd1: r = pix(i < s, s - i, s + 1, CSEL_LIT);
                  4'd2: r = pix(i < s, s - i, 0, CSEL_LIT);
                  4'd3: r = bar(1'b1, s + 1 - i, 1, s, CSEL_BLACK);
                  4'd4: r = bar(1'b1, s - i, 1, s, CSEL_LIT);
                  default: ;
               endcase
            end
            4'd3: begin
               case (j)
                  4'd0: r = bar(1'b1, i, 1, s, CSEL_BLACK);
                  4'd1: r = bar(1'b1, 1 + i, 1, s, CSEL_LIT);
                  default: ;
               endcase
            end
            4'd4: begin
               case (j)
                  4'd0: r = pix(1'b1, s - i, 2 * s + 2, CSEL_BLACK);
                  4'd1: r = pix(1'b1, 0, 2 * s + 1 - i, CSEL_LIT);
                  4'd2: r = pix(1'b1, 1 + i, 0, CSEL_BLACK);
                  default: ;
               endcase
            end
            4'd5: begin
               case (j)
                  4'd0: r = pix(1'b1, s + 1, s + 2 + i, CSEL_BLACK);
                  4'd1: r = pix(1'b1, s - i, 2 * s + 2, CSEL_LIT);
                  4'd2: r = pix(1'b1, s - i, 0, CSEL_LIT);
                  default: ;
               endcase
            end
            4'd6: begin
               case (j)
                  4'd0: r = bar(1'b1, s - i, 1, s, CSEL_LIT);
                  4'd1: r = bar(i > 0, s - i + 1, 1, s, CSEL_BLACK);
                  default: ;
               endcase
            end
            4'd7, 4'd1: begin
               case (j)
                  4'd0: r = bar(1'b1, i - 1, 1, s, CSEL_BLACK);
                  4'd1: r = bar(1'b1, i, 1, s, CSEL_LIT);
                  4'd2: r = bar(1'b1, i - 1, 2 * s + 1, s + 2, CSEL_BLACK);
                  4'd3: r = bar(1'b1, i, 2 * s + 1, s + 2, CSEL_LIT);
                  4'd4: r = (prog == 4'd1) ? pix(1'b1, 1 + i, 2 * s + 2, CSEL_BLACK)
                                           : pix(1'b1, 1 + i, 0, CSEL_BLACK);
                  4'd5: r = (prog == 4'd1) ? pix(1'b1, 1 + i, 0, CSEL_BLACK)
                                           : pix(1'b1, 1 + i, s + 1, CSEL_BLACK);
                  4'd6: r = pix(prog == 4'd1, 1 + i, s + 1, CSEL_BLACK);
                  default: ;
               endcase
            end
            4'd8: begin
               case (j)
                  4'd0: r = bar(1'b1, s - i, 2 * s + 1, s + 2, CSEL_LIT);
                  4'd1: r = bar(i > 0, s - i + 1, 2 * s + 1, s + 2, CSEL_BLACK);
                  4'd2: r = bar(1'b1, s - i, 1, s, CSEL_LIT);
                  4'd3: r = bar(i > 0, s - i + 1, 1, s, CSEL_BLACK);
                  4'd4: r = pix(i < s, s - i, 0, CSEL_LIT);
                  4'd5: r = pix(i < s, s - i, s + 1, CSEL_LIT);
                  default: ;
               endcase
            end
            4'd9: begin
               case (j)
                  4'd0: r = bar(1'b1, i - 1, 1, s, CSEL_BLACK);
                  4'd1: r = bar(1'b1, i, 1, s, CSEL_LIT);
                  default: ;
               endcase
            end
            4'd0: begin
               if (from == 4'd5) begin
                  case (j)
                     4'd0: r = bar(i < s && i > 0, 1 + i, 2 * s + 1, s + 2, CSEL_BLACK);
                     4'd1: r = bar(i < s, 2 + i, 2 * s + 1, s + 2, CSEL_LIT);
                     default: ;
                  endcase
               end else if (f123) begin
                  case (j)
                     4'd0: r = bar(1'b1, s - i, 2 * s + 1, s + 2, CSEL_LIT);
                     4'd1: r = bar(i > 0, s - i + 1, 2 * s + 1, s + 2, CSEL_BLACK);
                     default: ;
                  endcase
               end
               if (f59) begin
                  case (j)
                     4'd2: r = pix(i < s, s - i, s + 1, CSEL_BLACK);
                     4'd3: r = pix(i < s, 0, s - i, CSEL_LIT);
                     default: ;
                  endcase
               end else if (from == 4'd1) begin
                  case (j)
                     4'd2: r = bar(1'b1, s - i, 1, s, CSEL_LIT);
                     4'd3: r = bar(i > 0, s - i + 1, 1, s, CSEL_BLACK);
                     4'd4: r = pix(i < s, s - i, 2 * s + 2, CSEL_LIT);
                     4'd5: r = pix(i < s, s - i, 0, CSEL_LIT);
                     default: ;
                  endcase
               end else if (from == 4'd2) begin
                  case (j)
                     4'd2: r = pix(1'b1, 1 + i, s + 1, CSEL_BLACK);
                     4'd3: r = pix(i < s, s + 1, s + 1 - i, CSEL_LIT);
                     default: ;
                  endcase
               end else if (from == 4'd3) begin
                  case (j)
                     4'd2: r = bar(1'b1, s - i, 1, s, CSEL_LIT);
                     4'd3: r = bar(i > 0, s - i + 1, 1, s, CSEL_BLACK);
                     4'd4: r = pix(1'b1, s - i, s + 1, CSEL_BLACK);
                     default: ;
                  endcase
               end
            end
            default: ;
         endcase
      end
      return r;
   endfunction

endpackage

// ===== rtl/core/mdds_datapath.sv =====
// Datapath of the morphing digit draw sequencer: configuration, shown digit,
// request capture, slot decode, coordinate mapping and the output register.
// Depends on mdds_pkg.
`timescale 1ns / 1ps

module mdds_datapath import mdds_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_we,
   input  logic [1:0]   csr_index,
   input  logic [15:0]  csr_wdata,
   input  logic [23:0]  req_tdata,
   input  logic [3:0]   frame,
   input  logic [3:0]   slot,
   input  ctrl_cmd_type cmd,
   output dp_stat_type  stat,
   output logic [55:0]  rsp_tdata,
   output logic         rsp_tlast
);

   logic [5:0]  x_origin_ff;
   logic [4:0]  y_origin_ff;
   logic [15:0] lit_color_ff;
   logic [3:0]  shown_ff;
   logic [3:0]  shown_in;
   logic [3:0]  prog_ff, prog_in;
   logic [3:0]  from_ff;
   logic [7:0]  mask_ff, mask_in;
   logic [15:0] colon_ff;
   logic [55:0] data_ff, data_in;
   logic        last_ff;

   logic [1:0]  op;
   logic [3:0]  dig;
   logic        ok;
   slot_type    sl;
   logic [15:0] color;
   logic signed [9:0] px1, px2, py1, py2, ys;

   assign op  = req_tdata[1:0];
   assign dig = req_tdata[5:2];

   always_comb begin
      if (dig == 4'd0) begin
         ok = (shown_ff == 4'd1) || (shown_ff == 4'd2) || (shown_ff == 4'd3) ||
              (shown_ff == 4'd5) || (shown_ff == 4'd9);
      end else begin
         ok = (dig == shown_ff + 4'd1);
      end
      mask_in = (dig < 4'd10) ? SEG_MASKS[dig] : 8'h00;
      shown_in = shown_ff;
      prog_in  = PROG_DIRECT;
      case (op)
         OP_MORPH: begin
            shown_in = dig;
            prog_in  = (dig < 4'd10 && ok) ? dig : PROG_DIRECT;
         end
         OP_DRAW: begin
            shown_in = dig;
         end
         OP_COLON: prog_in = PROG_COLON;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x_origin_ff  <= '0;
         y_origin_ff  <= '0;
         lit_color_ff <= 16'hFFFF;
         shown_ff     <= '0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_X_ORIGIN:  x_origin_ff  <= csr_wdata[5:0];
               CSR_Y_ORIGIN:  y_origin_ff  <= csr_wdata[4:0];
               CSR_LIT_COLOR: lit_color_ff <= csr_wdata;
               default: ;
            endcase
         end
         if (cmd.load_req) shown_ff <= shown_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         prog_ff  <= prog_in;
         from_ff  <= shown_ff;
         mask_ff  <= mask_in;
         colon_ff <= req_tdata[21:6];
      end
      if (cmd.load_out) begin
         data_ff <= data_in;
         last_ff <= cmd.last;
      end
   end

   assign sl = cmd_slot(prog_ff, from_ff, frame, slot, mask_ff);

   always_comb begin
      case (sl.csel)
         CSEL_LIT:   color = lit_color_ff;
         CSEL_COLON: color = colon_ff;
         default:    color = 16'h0000;
      endcase
      px1 = $signed({4'b0, x_origin_ff}) + 10'(sl.x1);
      px2 = $signed({4'b0, x_origin_ff}) + 10'(sl.x2);
      py1 = 10'(PANEL_TOP_ROW) - (10'(sl.y1) + $signed({5'b0, y_origin_ff}));
      py2 = 10'(PANEL_TOP_ROW) - (10'(sl.y2) + $signed({5'b0, y_origin_ff}));
      ys  = py1 - (10'(sl.h) - 10'sd1);
      // fields low to high: kind, xs, ys, xe, ye, w, h, color
      case (sl.kind)
         KIND_RECT: data_in = {color, sl.h[3:0], sl.w[3:0], 7'd0, 8'd0,
                               ys[6:0], px1[7:0], sl.kind};
         KIND_SHOW: data_in = {16'd0, 4'd0, 4'd0, 7'd0, 8'd0, 7'd0, 8'd0, sl.kind};
         default:   data_in = {color, 4'd0, 4'd0, py2[6:0], px2[7:0],
                               py1[6:0], px1[7:0], sl.kind};
      endcase
   end

   assign stat.op_none = (op == OP_UNUSED);
   assign stat.slot_en = sl.en;
   assign stat.nframes = frame_count(prog_ff);
   assign rsp_tdata    = data_ff;
   assign rsp_tlast    = last_ff;

endmodule

// ===== rtl/core/mdds_controller.sv =====
// Controller of the morphing digit draw sequencer: walks frames and slots,
// handles both handshakes and caps a run at the result limit.
// Depends on mdds_pkg.
`timescale 1ns / 1ps

module mdds_controller import mdds_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  dp_stat_type  stat,
   output ctrl_cmd_type cmd,
   output logic [3:0]   frame,
   output logic [3:0]   slot
);

   state_type  state_ff, state_in;
   logic [3:0] frame_ff, frame_in;
   logic [3:0] slot_ff, slot_in;
   logic [5:0] count_ff, count_in;
   logic       last_ff, last_in;
   logic       run_end;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         frame_ff <= '0;
         slot_ff  <= '0;
         count_ff <= '0;
         last_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         frame_ff <= frame_in;
         slot_ff  <= slot_in;
         count_ff <= count_in;
         last_ff  <= last_in;
      end
   end

   assign run_end = ((slot_ff == SHOW_SLOT) && (frame_ff == stat.nframes - 4'd1)) ||
                    (count_ff == 6'(MAX_RESULTS - 1));

   always_comb begin
      state_in = state_ff;
      frame_in = frame_ff;
      slot_in  = slot_ff;
      count_in = count_ff;
      last_in  = last_ff;
      cmd      = '0;
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load_req = 1'b1;
               frame_in = '0;
               slot_in  = '0;
               count_in = '0;
               if (!stat.op_none) state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (stat.slot_en) begin
               cmd.load_out = 1'b1;
               cmd.last     = run_end;
               last_in      = run_end;
               state_in     = ST_SEND;
            end else begin
               slot_in = slot_ff + 4'd1;
            end
         end
         ST_SEND: begin
            rsp_tvalid = 1'b1;
            if (rsp_tready) begin
               count_in = count_ff + 6'd1;
               if (last_ff) begin
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_SCAN;
                  if (slot_ff == SHOW_SLOT) begin
                     slot_in  = '0;
                     frame_in = frame_ff + 4'd1;
                  end else begin
                     slot_in = slot_ff + 4'd1;
                  end
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign frame = frame_ff;
   assign slot  = slot_ff;

endmodule

// ===== rtl/core/morphing_digit_draw_sequencer.sv =====
// Morphing digit draw sequencer, top level.
// One request at a time: the controller scans all nine slots of every frame in order,
// moves each enabled slot's command through the output register and sends it (a morph
// to 1 gives 8 frames, 64 commands). The first command is valid once the request has
// been captured and the first enabled slot has been loaded into the output register.
// Operation 3 is accepted with no output. Output back-pressure holds the scan.
// Synchronous active-high reset: shown digit 0, origins 0, lit color 0xFFFF.
`timescale 1ns / 1ps

module morphing_digit_draw_sequencer import mdds_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // operation[1:0], target_digit[5:2], colon_color[21:6]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // command_kind[1:0], x_start[9:2], y_start[16:10],
                                    // x_end[24:17], y_end[31:25], rect_width[35:32],
                                    // rect_height[39:36], draw_color[55:40]
   output logic        rsp_tlast
);

   ctrl_cmd_type cmd;
   dp_stat_type  stat;
   logic [3:0]   frame;
   logic [3:0]   slot;

   mdds_controller u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .cmd        (cmd),
      .frame      (frame),
      .slot       (slot)
   );

   mdds_datapath u_dp (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_tdata (req_tdata),
      .frame     (frame),
      .slot      (slot),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_tdata (rsp_tdata),
      .rsp_tlast (rsp_tlast)
   );

endmodule
